// ===== hdl/pbh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar bin histogram package
// Sizes, operation codes and the structs that pass between the histogram
// modules.
// ----------------------------------------------------------------------------
package pbh_pkg;

    localparam int ANGLE_BINS  = 16;
    localparam int RADIUS_BINS = 8;
    localparam int COUNT_WIDTH = 20;

    localparam int NUM_BINS = ANGLE_BINS * RADIUS_BINS;
    localparam int AE_N     = ANGLE_BINS + 1;
    localparam int RE_N     = RADIUS_BINS + 1;
    localparam int AE_IDX_W = $clog2(AE_N);
    localparam int RE_IDX_W = $clog2(RE_N);
    localparam int ROW_W    = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
    localparam int COL_W    = (RADIUS_BINS > 1) ? $clog2(RADIUS_BINS) : 1;
    localparam int IDX_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    // Port field widths.
    localparam int OP_W        = 3;
    localparam int SLOT_W      = 7;
    localparam int ANGLE_W     = 20;
    localparam int RADIUS_W    = 32;
    localparam int BIN_ROW_W   = 4;
    localparam int BIN_COL_W   = 3;
    localparam int BIN_COUNT_W = 20;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd0;
    localparam logic [OP_W-1:0] OP_ANGLE_EDGE  = 3'd1;
    localparam logic [OP_W-1:0] OP_RADIUS_EDGE = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD         = 3'd3;
    localparam logic [OP_W-1:0] OP_READ        = 3'd4;

    typedef struct packed {
        logic              angle_we;
        logic              radius_we;
        logic [SLOT_W-1:0] slot;
    } t_edge_wr;

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_bin_hit;

    typedef struct packed {
        logic             add;
        logic             read;
        logic             clear;
        logic [IDX_W-1:0] idx;
    } t_count_req;

endpackage

// ===== hdl/pbh_locate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar bin histogram edge store and bin search
// Holds the angle and radius edge lists and finds, for a point, the bin
// below the first edge that lies strictly above each coordinate.
// ----------------------------------------------------------------------------
module pbh_locate
    import pbh_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_edge_wr                   i_wr,
    input  logic signed [ANGLE_W-1:0]  i_angle,
    input  logic        [RADIUS_W-1:0] i_radius,
    output t_bin_hit                   o_hit
);

    logic signed [ANGLE_W-1:0]  r_angle_edges  [AE_N];
    logic        [RADIUS_W-1:0] r_radius_edges [RE_N];

    logic [AE_N-1:0]     a_lt;
    logic [RE_N-1:0]     r_lt;
    logic                a_found;
    logic                r_found;
    logic [AE_IDX_W-1:0] a_first;
    logic [RE_IDX_W-1:0] r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AE_N; i++) r_angle_edges[i] <= '0;
            for (int j = 0; j < RE_N; j++) r_radius_edges[j] <= '0;
        end else begin
            // Slots beyond the end of a list are ignored.
            if (i_wr.angle_we && (32'(i_wr.slot) <= ANGLE_BINS)) begin
                r_angle_edges[i_wr.slot[AE_IDX_W-1:0]] <= i_angle;
            end
            if (i_wr.radius_we && (32'(i_wr.slot) <= RADIUS_BINS)) begin
                r_radius_edges[i_wr.slot[RE_IDX_W-1:0]] <= i_radius;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < AE_N; i++) a_lt[i] = i_angle < r_angle_edges[i];
        for (int j = 0; j < RE_N; j++) r_lt[j] = i_radius < r_radius_edges[j];
    end

    // Lowest set compare wins; the downward loop leaves the smallest index.
    always_comb begin
        a_found = 1'b0;
        a_first = '0;
        for (int i = AE_N - 1; i >= 0; i--) begin
            if (a_lt[i]) begin
                a_found = 1'b1;
                a_first = AE_IDX_W'(i);
            end
        end
        r_found = 1'b0;
        r_first = '0;
        for (int j = RE_N - 1; j >= 0; j--) begin
            if (r_lt[j]) begin
                r_found = 1'b1;
                r_first = RE_IDX_W'(j);
            end
        end
    end

    // A value below the first edge has no bin, nor one above every edge.
    always_comb begin
        o_hit.hit = a_found && (a_first != '0) && r_found && (r_first != '0);
        o_hit.row = ROW_W'(a_first - AE_IDX_W'(1));
        o_hit.col = COL_W'(r_first - RE_IDX_W'(1));
    end

endmodule

// ===== hdl/pbh_counts.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar bin histogram count store
// Bin count memory with per-bin valid flags, a registered read, and a
// saturating read-modify-write that forwards a count still being written.
// ----------------------------------------------------------------------------
module pbh_counts
    import pbh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_count_req             i_req,
    output logic [COUNT_WIDTH-1:0] o_count
);

    logic [COUNT_WIDTH-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    r_valid;

    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic                   r_fwd;
    logic [COUNT_WIDTH-1:0] r_fwd_data;
    logic                   r_s2_add;
    logic [IDX_W-1:0]       r_s2_idx;

    logic [COUNT_WIDTH-1:0] base;
    logic [COUNT_WIDTH-1:0] n_count;

    // A bin whose flag is clear reads as zero.
    always_comb begin
        if (r_fwd) begin
            base = r_fwd_data;
        end else if (r_rd_vld) begin
            base = r_rd_data;
        end else begin
            base = '0;
        end
        n_count = (base == COUNT_MAX) ? base : base + COUNT_WIDTH'(1);
        o_count = r_s2_add ? n_count : base;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.idx];
        r_rd_vld  <= r_valid[i_req.idx];
        r_s2_idx  <= i_req.idx;
        // The beat ahead writes this bin on the same edge as the read.
        r_fwd_data <= n_count;
        if (r_s2_add) begin
            r_mem[r_s2_idx] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_s2_add <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            r_s2_add <= i_req.add;
            r_fwd    <= r_s2_add && (i_req.add || i_req.read) && (i_req.idx == r_s2_idx);
            // A clear is the later beat, so it overrides a pending write.
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (r_s2_add) begin
                r_valid[r_s2_idx] <= 1'b1;
            end
        end
    end

endmodule

// ===== hdl/polar_bin_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar bin histogram
// Two-dimensional histogram of angle and radius points over loaded edges.
// ----------------------------------------------------------------------------
// A command is taken on every clock edge at which start is high and busy is
// low; busy is high during reset and for the first cycle after it, so one
// command per cycle is sustained from then on. Every command gives exactly one
// result, shown for one cycle with o_strobe: the command register feeds the
// edge compares and the count memory read, the saturating update follows and
// lands in the result register, which drives the ports. Results come out in
// command order and cannot be held off. Results of commands with no readout
// carry zero.
// ----------------------------------------------------------------------------
module polar_bin_histogram
    import pbh_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic        [OP_W-1:0]     i_op,
    input  logic        [SLOT_W-1:0]   i_slot,
    input  logic signed [ANGLE_W-1:0]  i_angle,
    input  logic        [RADIUS_W-1:0] i_radius,
    output logic                       o_strobe,
    output logic                       o_counted,
    output logic        [BIN_ROW_W-1:0]   o_bin_row,
    output logic        [BIN_COL_W-1:0]   o_bin_col,
    output logic        [BIN_COUNT_W-1:0] o_bin_count
);

    logic r_busy;

    // Command stage.
    logic                       r_s1_vld;
    logic [OP_W-1:0]            r_s1_op;
    logic [SLOT_W-1:0]          r_s1_slot;
    logic signed [ANGLE_W-1:0]  r_s1_angle;
    logic [RADIUS_W-1:0]        r_s1_radius;

    // Memory read stage.
    logic               r_s2_vld;
    logic               r_s2_cnt_en;
    logic               r_s2_counted;
    logic [ROW_W-1:0]   r_s2_row;
    logic [COL_W-1:0]   r_s2_col;

    // Result stage.
    logic                   r_strobe;
    logic                   r_counted;
    logic [BIN_ROW_W-1:0]   r_bin_row;
    logic [BIN_COL_W-1:0]   r_bin_col;
    logic [BIN_COUNT_W-1:0] r_bin_count;

    t_edge_wr               edge_wr;
    t_bin_hit               bin_hit;
    t_count_req             cnt_req;
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   is_add;
    logic                   is_read;
    logic                   is_clear;
    logic                   n_s2_counted;
    logic                   n_s2_cnt_en;

    always_comb begin
        is_add            = 1'b0;
        is_read           = 1'b0;
        is_clear          = 1'b0;
        edge_wr.angle_we  = 1'b0;
        edge_wr.radius_we = 1'b0;
        edge_wr.slot      = r_s1_slot;
        unique case (r_s1_op)
            OP_CLEAR:       is_clear          = r_s1_vld;
            OP_ANGLE_EDGE:  edge_wr.angle_we  = r_s1_vld;
            OP_RADIUS_EDGE: edge_wr.radius_we = r_s1_vld;
            OP_ADD:         is_add            = r_s1_vld;
            OP_READ:        is_read           = r_s1_vld && (32'(r_s1_slot) < NUM_BINS);
            default:        ;
        endcase
    end

    pbh_locate u_locate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (edge_wr),
        .i_angle  (r_s1_angle),
        .i_radius (r_s1_radius),
        .o_hit    (bin_hit)
    );

    always_comb begin
        n_s2_counted  = is_add && bin_hit.hit;
        n_s2_cnt_en   = n_s2_counted || is_read;
        cnt_req.add   = n_s2_counted;
        cnt_req.read  = is_read;
        cnt_req.clear = is_clear;
        if (is_add) begin
            cnt_req.idx = IDX_W'(IDX_W'(bin_hit.row) * IDX_W'(RADIUS_BINS))
                        + IDX_W'(bin_hit.col);
        end else begin
            cnt_req.idx = IDX_W'(r_s1_slot);
        end
    end

    pbh_counts u_counts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cnt_req),
        .o_count (cnt)
    );

    always_ff @(posedge i_clk) begin
        r_s1_op     <= i_op;
        r_s1_slot   <= i_slot;
        r_s1_angle  <= i_angle;
        r_s1_radius <= i_radius;

        r_s2_row <= bin_hit.row;
        r_s2_col <= bin_hit.col;

        r_counted   <= r_s2_counted;
        r_bin_row   <= r_s2_counted ? BIN_ROW_W'(r_s2_row) : '0;
        r_bin_col   <= r_s2_counted ? BIN_COL_W'(r_s2_col) : '0;
        r_bin_count <= r_s2_cnt_en ? BIN_COUNT_W'(cnt) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_s2_cnt_en  <= 1'b0;
            r_s2_counted <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_busy       <= 1'b0;
            r_s1_vld     <= start && !r_busy;
            r_s2_vld     <= r_s1_vld;
            r_s2_cnt_en  <= n_s2_cnt_en;
            r_s2_counted <= n_s2_counted;
            r_strobe     <= r_s2_vld;
        end
    end

    assign busy        = r_busy;
    assign o_strobe    = r_strobe;
    assign o_counted   = r_counted;
    assign o_bin_row   = r_bin_row;
    assign o_bin_col   = r_bin_col;
    assign o_bin_count = r_bin_count;

endmodule

// ===== hdl/pbh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar bin histogram port checker
// Watches the top level ports for result timing and result field rules.
// ----------------------------------------------------------------------------
module pbh_checker
    import pbh_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic [OP_W-1:0]        i_op,
    input logic                   o_strobe,
    input logic                   o_counted,
    input logic [BIN_ROW_W-1:0]   o_bin_row,
    input logic [BIN_COL_W-1:0]   o_bin_col,
    input logic [BIN_COUNT_W-1:0] o_bin_count
);

    // Every accepted beat gives its result with o_strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_strobe)
        else $error("accepted beat gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 3))
        else $error("result without an accepted beat");

    a_counted_from_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_counted |-> (o_strobe && ($past(i_op, 3) == OP_ADD)))
        else $error("counted set for a beat that added no point");

    a_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_counted) |-> ((o_bin_row == '0) && (o_bin_col == '0)))
        else $error("bin position shown for an uncounted beat");

    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_op, 3) != OP_ADD) && ($past(i_op, 3) != OP_READ))
        |-> (o_bin_count == '0))
        else $error("count shown for a beat with no readout");

endmodule

bind polar_bin_histogram pbh_checker u_pbh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_op        (i_op),
    .o_strobe    (o_strobe),
    .o_counted   (o_counted),
    .o_bin_row   (o_bin_row),
    .o_bin_col   (o_bin_col),
    .o_bin_count (o_bin_count)
);
